FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/lru_pkg.sv
// Shared widths, defaults and bus field positions for the LRU page table.
// No dependencies.
package lru_pkg;

    localparam int PAGE_W         = 6;
    localparam int FRAME_W        = 5;
    localparam int CFG_W          = 6;
    localparam int MAX_FRAMES_DEF = 32;
    localparam int PAGE_COUNT_DEF = 64;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    localparam int TU_HIT    = 0;
    localparam int TU_LOADED = 1;
    localparam int TU_EVICT  = 2;

    localparam int TD_FRAME_LSB = 0;
    localparam int TD_EVPG_LSB  = FRAME_W;

endpackage

FILE: hdl/lru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lru_page_replacement_top.sv
// A reference is accepted in IDLE, the tags of the first n frames are read in SWEEP, where n is frames_in_use
// held to 1..MAX_FRAMES, the table is updated in UPDATE and the result is held in OUT until m_tready.
// A new reference is taken only after the result of the last one has been accepted; the sweep goes
// through the single RAM read port and the shared rank comparator.
// Reset (aresetn low, synchronous): table empty, all ranks zero, frames_in_use = 32.
// Depends on lru_pkg and lru_ram.
module lru_page_replacement_top
    import lru_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,     // frames_in_use
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // [5:0] page
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // [4:0] frame, [10:5] evicted_page
    output logic [M_TUSER_W-1:0] m_tuser       // [0] hit, [1] loaded_free, [2] evicted_valid
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned PAGE_MAX = PAGE_COUNT - 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg, cfg_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]     filled_reg, filled_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 chk_v_reg, chk_v_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]     rank_q_reg, rank_q_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     found_idx_reg, found_idx_next;
    logic [IDX_W-1:0]     found_rank_reg, found_rank_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]     best_rank_reg, best_rank_next;
    logic [PAGE_W-1:0]    best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]     rank_reg [MAX_FRAMES];
    logic [IDX_W-1:0]     rank_next [MAX_FRAMES];
    logic                 hit_reg, hit_next;
    logic                 loaded_reg, loaded_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [PAGE_W-1:0]    ev_page_reg, ev_page_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;

    logic [PAGE_W-1:0]    page_in;
    logic [PAGE_W-1:0]    page_clamped;
    logic [CNT_W-1:0]     limit_c;
    logic [PAGE_W-1:0]    tag_rd;
    logic                 ram_we;
    logic [IDX_W-1:0]     upd_f;
    logic [IDX_W-1:0]     upd_r;
    logic                 upd_load;
    logic                 upd_evict;
    logic                 chk_match;
    logic                 chk_last;

    assign page_in      = s_tdata[PAGE_W-1:0];
    assign page_clamped = (32'(page_in) > PAGE_MAX) ? PAGE_W'(PAGE_MAX) : page_in;

    always_comb begin
        if (cfg_reg == '0) begin
            limit_c = CNT_W'(1);
        end else if (32'(cfg_reg) > 32'(MAX_FRAMES)) begin
            limit_c = CNT_W'(MAX_FRAMES);
        end else begin
            limit_c = CNT_W'(cfg_reg);
        end
    end

    lru_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_FRAMES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (upd_f),
        .wdata (page_reg),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (tag_rd)
    );

    assign chk_match = chk_v_reg && !found_reg && (CNT_W'(chk_idx_reg) < filled_reg)
                       && (tag_rd == page_reg);
    assign chk_last  = chk_v_reg && (CNT_W'(chk_idx_reg) == limit_reg - CNT_W'(1));

    always_comb begin
        upd_load  = 1'b0;
        upd_evict = 1'b0;
        if (found_reg) begin
            upd_f = found_idx_reg;
            upd_r = found_rank_reg;
        end else if (filled_reg < limit_reg) begin
            upd_f    = filled_reg[IDX_W-1:0];
            upd_r    = '0;
            upd_load = 1'b1;
        end else begin
            upd_f     = best_idx_reg;
            upd_r     = best_rank_reg;
            upd_evict = 1'b1;
        end
    end

    assign ram_we = (state_reg == ST_UPDATE) && !found_reg;

    always_comb begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        page_next       = page_reg;
        limit_next      = limit_reg;
        filled_next     = filled_reg;
        rd_cnt_next     = rd_cnt_reg;
        chk_v_next      = 1'b0;
        chk_idx_next    = rd_cnt_reg[IDX_W-1:0];
        rank_q_next     = rank_reg[rd_cnt_reg[IDX_W-1:0]];
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        best_idx_next   = best_idx_reg;
        best_rank_next  = best_rank_reg;
        best_tag_next   = best_tag_reg;
        rank_next       = rank_reg;
        hit_next        = hit_reg;
        loaded_next     = loaded_reg;
        ev_valid_next   = ev_valid_reg;
        ev_page_next    = ev_page_reg;
        frame_next      = frame_reg;

        if (cfg_valid) begin
            cfg_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    page_next   = page_clamped;
                    limit_next  = limit_c;
                    rd_cnt_next = '0;
                    found_next  = 1'b0;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (rd_cnt_reg < limit_reg) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    chk_v_next  = 1'b1;
                end
                if (chk_match) begin
                    found_next      = 1'b1;
                    found_idx_next  = chk_idx_reg;
                    found_rank_next = rank_q_reg;
                end
                if (chk_v_reg && (chk_idx_reg == '0 || rank_q_reg > best_rank_reg)) begin
                    best_idx_next  = chk_idx_reg;
                    best_rank_next = rank_q_reg;
                    best_tag_next  = tag_rd;
                end
                if (chk_last) begin
                    chk_v_next = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    if (IDX_W'(i) == upd_f) begin
                        rank_next[i] = '0;
                    end else if ((CNT_W'(i) < filled_reg) &&
                                 (upd_load || rank_reg[i] < upd_r)) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                if (upd_load) begin
                    filled_next = filled_reg + CNT_W'(1);
                end
                hit_next      = found_reg;
                loaded_next   = upd_load;
                ev_valid_next = upd_evict;
                ev_page_next  = upd_evict ? best_tag_reg : '0;
                frame_next    = FRAME_W'(upd_f);
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cfg_reg    <= CFG_RESET;
            filled_reg <= '0;
            chk_v_reg  <= 1'b0;
            found_reg  <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            cfg_reg    <= cfg_next;
            filled_reg <= filled_next;
            chk_v_reg  <= chk_v_next;
            found_reg  <= found_next;
            rank_reg   <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg       <= page_next;
        limit_reg      <= limit_next;
        rd_cnt_reg     <= rd_cnt_next;
        chk_idx_reg    <= chk_idx_next;
        rank_q_reg     <= rank_q_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        best_idx_reg   <= best_idx_next;
        best_rank_reg  <= best_rank_next;
        best_tag_reg   <= best_tag_next;
        hit_reg        <= hit_next;
        loaded_reg     <= loaded_next;
        ev_valid_reg   <= ev_valid_next;
        ev_page_reg    <= ev_page_next;
        frame_reg      <= frame_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {(M_TDATA_W - FRAME_W - PAGE_W)'(0), ev_page_reg, frame_reg};
    assign m_tuser   = {ev_valid_reg, loaded_reg, hit_reg};

endmodule

FILE: hdl/lru_chk.sv
// Port-level checker for the LRU page table, bound to the top level.
// Depends on lru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lru_chk
    import lru_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    `ASSERT_IMP(a_one_outcome, aclk, aresetn, m_tvalid, $onehot(m_tuser))
    `ASSERT_IMP(a_evpage_zero, aclk, aresetn, m_tvalid && !m_tuser[TU_EVICT],
                m_tdata[TD_EVPG_LSB+PAGE_W-1:TD_EVPG_LSB] == '0)
    `ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready,
                !s_tready && !m_tvalid)
    `ASSERT_IMP(a_no_accept_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
